// File: hdl/pjtt_pkg.sv
//------------------------------------------------------------------------------
// pjtt_pkg: shared types and constants of the periodic job timer table
// Field widths, item kinds, result status codes and per-slot job phases.
//------------------------------------------------------------------------------
`default_nettype none

package pjtt_pkg;

	localparam int unsigned SLOTS_DEF = 16;   // default slot count
	localparam int unsigned MAX_SLOTS = 16;   // slots reachable by slot and mask fields
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned TICK_W    = 32;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned MASK_W    = 16;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned S_DATA_W  = 72;   // 32 + 32 + 4, padded to bytes
	localparam int unsigned M_DATA_W  = 56;   // 2 + 4 + 16 + 32, padded to bytes

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_KILL = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_ZERO_INTV = 2'd2,
		STAT_NOT_USED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_FREE         = 3'd0,
		PH_WAIT_DELAY   = 3'd1,
		PH_WAIT_NODELAY = 3'd2,
		PH_DELAYED      = 3'd3,
		PH_RUNNING      = 3'd4,
		PH_EXIT         = 3'd5
	} phase_t;

endpackage

`default_nettype wire

// File: hdl/periodic_job_timer_table_top.sv
//------------------------------------------------------------------------------
// periodic_job_timer_table_top: table of periodic job timers
// Add and kill requests pass from accept through the result hand-off state to
// the output register. A tick request walks every usable slot in turn, running
// the shared remainder unit for each running job, then hands off its result.
// One request at a time; a new one is taken while the last result waits.
// Reset: all slots free, tick counter one, output empty.
//------------------------------------------------------------------------------
`default_nettype none

module periodic_job_timer_table_top #(
	parameter int unsigned SLOTS = pjtt_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// [31:0] delay_ticks, [63:32] interval_ticks, [67:64] slot, [71:68] zero
	input  wire logic [pjtt_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] kind
	input  wire logic [pjtt_pkg::KIND_W-1:0]   s_tuser,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [1:0] status, [5:2] assigned_slot, [21:6] fire_mask, [53:22] tick_value,
	// [55:54] zero
	output      logic [pjtt_pkg::M_DATA_W-1:0] m_tdata
);

	import pjtt_pkg::*;

	// Only the first sixteen slots are reachable through the slot and mask fields.
	localparam int unsigned USABLE   = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
	localparam int unsigned IDX_W    = (USABLE > 1) ? $clog2(USABLE) : 1;
	localparam int unsigned CMP_W    = SLOT_W + 1;
	localparam int unsigned STEP_W   = $clog2(TICK_W);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(USABLE - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);
	localparam logic [MASK_W-1:0] USE_MASK  = MASK_W'((32'd1 << USABLE) - 32'd1);

	// Sequencer: idle, per-slot scan, remainder iterations, result hand-off.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} seq_state_t;

	// Request fields
	logic [TICK_W-1:0] in_delay;
	logic [TICK_W-1:0] in_intv;
	logic [SLOT_W-1:0] in_slot;
	kind_t             in_kind;
	logic              s_hs;

	assign in_delay = s_tdata[TICK_W-1:0];
	assign in_intv  = s_tdata[2*TICK_W-1:TICK_W];
	assign in_slot  = s_tdata[2*TICK_W+SLOT_W-1:2*TICK_W];
	assign in_kind  = kind_t'(s_tuser);

	// Control state
	seq_state_t         state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [STEP_W-1:0]  step_q;
	phase_t             phase_q [USABLE];
	logic [TICK_W-1:0]  tick_q;
	logic [MASK_W-1:0]  mask_q;

	// Job parameters and timing marks; written before they are ever read
	logic [TICK_W-1:0]  anchor_q [USABLE];
	logic [TICK_W-1:0]  dend_q   [USABLE];
	logic [TICK_W-1:0]  delay_q  [USABLE];
	logic [TICK_W-1:0]  intv_q   [USABLE];

	// Shared remainder unit: one restoring step per cycle
	logic [TICK_W-1:0]  rem_q;
	logic [TICK_W-1:0]  dvd_q;
	logic [TICK_W:0]    rem_trial;
	logic [TICK_W:0]    rem_diff;
	logic [TICK_W-1:0]  rem_nxt;

	// Pending result, then the output register
	status_t            p_status_q;
	logic [SLOT_W-1:0]  p_slot_q;
	logic [TICK_W-1:0]  p_tick_q;
	logic               o_valid_q;
	status_t            o_status_q;
	logic [SLOT_W-1:0]  o_slot_q;
	logic [MASK_W-1:0]  o_mask_q;
	logic [TICK_W-1:0]  o_tick_q;

	// Lowest free slot for an add
	logic               any_free;
	logic [IDX_W-1:0]   free_idx;
	logic               kill_ok;
	logic [IDX_W-1:0]   kill_idx;

	// Per-slot outcome of the walk
	phase_t             cur_ph;
	logic [TICK_W-1:0]  cur_intv;
	logic               slot_done;
	logic               slot_fire;
	logic               out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_hs     = s_tvalid && s_tready;
	assign out_load = (state_q == ST_FIN) && (!o_valid_q || m_tready);

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = USABLE - 1; i >= 0; i--) begin
			if (phase_q[i] == PH_FREE) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign kill_idx = in_slot[IDX_W-1:0];
	assign kill_ok  = ({1'b0, in_slot} < CMP_W'(USABLE)) && (phase_q[kill_idx] != PH_FREE);

	assign cur_ph   = phase_q[idx_q];
	assign cur_intv = intv_q[idx_q];

	// Shift in the next dividend bit, subtract the interval when it fits.
	assign rem_trial = {rem_q, dvd_q[TICK_W-1]};
	assign rem_diff  = rem_trial - {1'b0, cur_intv};
	assign rem_nxt   = rem_diff[TICK_W] ? rem_trial[TICK_W-1:0] : rem_diff[TICK_W-1:0];

	always_comb begin
		slot_done = 1'b0;
		slot_fire = 1'b0;
		case (state_q)
			ST_SCAN: begin
				slot_done = (cur_ph != PH_RUNNING);
				case (cur_ph)
					PH_WAIT_NODELAY: slot_fire = 1'b1;
					PH_DELAYED:      slot_fire = (tick_q == dend_q[idx_q]);
					default:         slot_fire = 1'b0;
				endcase
			end
			ST_DIV: begin
				slot_done = (step_q == LAST_STEP);
				slot_fire = (rem_nxt == '0) && (cur_intv != '0);
			end
			default: begin
				slot_done = 1'b0;
				slot_fire = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			step_q    <= '0;
			tick_q    <= TICK_W'(1);
			mask_q    <= '0;
			o_valid_q <= 1'b0;
			for (int i = 0; i < USABLE; i++) begin
				phase_q[i] <= PH_FREE;
			end
		end else begin
			// Hold the output until taken; a new load replaces a taken one.
			if (out_load) begin
				o_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_hs) begin
						mask_q <= '0;
						idx_q  <= '0;
						case (in_kind)
							KIND_TICK: begin
								state_q <= ST_SCAN;
							end
							KIND_ADD: begin
								if (in_intv != '0 && any_free) begin
									phase_q[free_idx] <= (in_delay != '0) ? PH_WAIT_DELAY
									                                      : PH_WAIT_NODELAY;
								end
								state_q <= ST_FIN;
							end
							KIND_KILL: begin
								if (kill_ok) begin
									phase_q[kill_idx] <= PH_EXIT;
								end
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					case (cur_ph)
						PH_EXIT:         phase_q[idx_q] <= PH_FREE;
						PH_WAIT_DELAY:   phase_q[idx_q] <= PH_DELAYED;
						PH_WAIT_NODELAY: phase_q[idx_q] <= PH_RUNNING;
						PH_DELAYED: begin
							if (slot_fire) begin
								phase_q[idx_q] <= PH_RUNNING;
							end
						end
						default: begin
						end
					endcase
					if (cur_ph == PH_RUNNING) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Leave the current slot: mark a firing, step to the next or finish.
			if (slot_done) begin
				if (slot_fire) begin
					mask_q <= mask_q | (MASK_W'(1) << idx_q);
				end
				if (idx_q == LAST_IDX) begin
					tick_q  <= tick_q + TICK_W'(1);
					state_q <= ST_FIN;
				end else begin
					idx_q   <= idx_q + IDX_W'(1);
					state_q <= ST_SCAN;
				end
			end
		end
	end

	// Job store, remainder unit and result payload
	always_ff @(posedge clk) begin
		if (s_hs) begin
			p_status_q <= STAT_OK;
			p_slot_q   <= '0;
			p_tick_q   <= '0;
			case (in_kind)
				KIND_TICK: begin
					p_tick_q <= tick_q;
				end
				KIND_ADD: begin
					if (in_intv == '0) begin
						p_status_q <= STAT_ZERO_INTV;
					end else if (!any_free) begin
						p_status_q <= STAT_FULL;
					end else begin
						delay_q[free_idx] <= in_delay;
						intv_q[free_idx]  <= in_intv;
						p_slot_q          <= SLOT_W'(free_idx);
					end
				end
				KIND_KILL: begin
					if (!kill_ok) begin
						p_status_q <= STAT_NOT_USED;
					end
				end
				default: begin
				end
			endcase
		end

		if (state_q == ST_SCAN) begin
			case (cur_ph)
				PH_WAIT_DELAY: begin
					anchor_q[idx_q] <= tick_q;
					dend_q[idx_q]   <= tick_q + delay_q[idx_q];
				end
				PH_WAIT_NODELAY: begin
					anchor_q[idx_q] <= tick_q;
				end
				PH_RUNNING: begin
					rem_q <= '0;
					dvd_q <= tick_q - anchor_q[idx_q];
				end
				default: begin
				end
			endcase
		end

		if (state_q == ST_DIV) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
		end

		if (out_load) begin
			o_status_q <= p_status_q;
			o_slot_q   <= p_slot_q;
			o_mask_q   <= mask_q;
			o_tick_q   <= p_tick_q;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {(M_DATA_W - STATUS_W - SLOT_W - MASK_W - TICK_W)'(0),
	                   o_tick_q, o_mask_q, o_slot_q, o_status_q};

	// A running job always holds a nonzero interval for the remainder unit.
	a_div_intv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cur_intv != '0))
		else $error("remainder unit started on a zero interval");

	// The tick counter only ever moves forward by one.
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> (tick_q == $past(tick_q) + TICK_W'(1)))
		else $error("tick counter moved by other than one");

	// Firings appear only on usable slots of a successful tick result.
	a_mask_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && (o_mask_q != '0)) |->
		(((o_mask_q & ~USE_MASK) == '0) && (o_status_q == STAT_OK) && (o_slot_q == '0)))
		else $error("fire mask on a non-tick result or an unusable slot");

endmodule

`default_nettype wire
